// File: hw/rtl/pcx_rle_decoder_defines.svh
`ifndef PCX_RLE_DECODER_DEFINES_SVH
`define PCX_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcx_rle_decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcx_rle_decoder: next-cycle check failed");

`endif

// File: hw/rtl/pcx_rle_pkg.sv
package pcx_rle_pkg;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RUN_W   = 6;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(240);

  localparam logic [1:0] RUN_MARK = 2'b11;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic take;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic total_ok;
    logic run_start;
    logic run_last;
  } dp_stat_t;

endpackage

// File: hw/rtl/pcx_rle_ctrl.sv
module pcx_rle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcx_rle_pkg::dp_stat_t stat,
  output pcx_rle_pkg::dp_cmd_t  cmd
);
  import pcx_rle_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && stat.slot_free && stat.total_ok;
  assign cmd.take = in_valid && in_ready;
  assign cmd.step = (state == S_RUN) && stat.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.take && stat.run_start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cmd.step && stat.run_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/pcx_rle_dp.sv
module pcx_rle_dp #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pcx_rle_pkg::CFG_W-1:0]   cfg_data,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]  code_byte,
  input  logic                            image_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcx_rle_pkg::BYTE_W-1:0]  pixel,
  output logic                            run_end,
  output logic                            image_done,
  input  pcx_rle_pkg::dp_cmd_t            cmd,
  output pcx_rle_pkg::dp_stat_t           stat
);
  import pcx_rle_pkg::*;

  localparam int unsigned SIDE_LIMIT = (MAX_SIDE < CFG_MAX) ? MAX_SIDE : CFG_MAX;
  localparam int unsigned SIDE_W     = $clog2(SIDE_LIMIT + 1);
  localparam int unsigned TOT_W      = 2 * SIDE_W;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [SIDE_W-1:0] width_clamped;
  logic [SIDE_W-1:0] height_clamped;
  logic [TOT_W-1:0]  total;
  logic              total_ok;

  logic [TOT_W-1:0]  count;
  logic [TOT_W-1:0]  count_next;
  logic              awaiting;
  logic              awaiting_next;
  logic [RUN_W-1:0]  pending;
  logic [RUN_W-1:0]  pending_next;
  logic [RUN_W-1:0]  left;
  logic [RUN_W-1:0]  left_next;
  logic [BYTE_W-1:0] held;
  logic [BYTE_W-1:0] held_next;

  logic              emit;
  logic [BYTE_W-1:0] emit_pixel;
  logic              emit_run_end;
  logic              emit_done;
  logic              run_start;

  logic [TOT_W-1:0]  cnt_eff;
  logic              await_eff;
  logic              full;
  logic [TOT_W-1:0]  cnt_inc;
  logic [TOT_W-1:0]  run_inc;
  logic              run_last;

  always_comb begin
    if (image_width == '0) begin
      width_clamped = SIDE_W'(1);
    end else if (32'(image_width) > SIDE_LIMIT) begin
      width_clamped = SIDE_W'(SIDE_LIMIT);
    end else begin
      width_clamped = image_width[SIDE_W-1:0];
    end
    if (image_height == '0) begin
      height_clamped = SIDE_W'(1);
    end else if (32'(image_height) > SIDE_LIMIT) begin
      height_clamped = SIDE_W'(SIDE_LIMIT);
    end else begin
      height_clamped = image_height[SIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      total_ok     <= 1'b0;
    end else begin
      total_ok <= !cfg_we;
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_WIDTH:  image_width  <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total <= TOT_W'(width_clamped) * TOT_W'(height_clamped);
  end

  assign cnt_eff   = image_start ? '0 : count;
  assign await_eff = !image_start && awaiting;
  assign full      = cnt_eff >= total;
  assign cnt_inc   = cnt_eff + TOT_W'(1);
  assign run_inc   = count + TOT_W'(1);
  assign run_last  = (left == RUN_W'(1)) || (run_inc == total);

  always_comb begin
    count_next    = count;
    awaiting_next = awaiting;
    pending_next  = pending;
    left_next     = left;
    held_next     = held;
    emit          = 1'b0;
    emit_pixel    = code_byte;
    emit_run_end  = 1'b1;
    emit_done     = 1'b0;
    run_start     = 1'b0;

    if (await_eff && (pending != '0) && !full) begin
      run_start = !((pending == RUN_W'(1)) || (cnt_inc == total));
    end

    if (cmd.take) begin
      count_next    = cnt_eff;
      awaiting_next = await_eff;
      pending_next  = image_start ? '0 : pending;
      if (!full) begin
        if (await_eff) begin
          awaiting_next = 1'b0;
          pending_next  = '0;
          if (pending != '0) begin
            emit         = 1'b1;
            emit_done    = cnt_inc == total;
            emit_run_end = !run_start;
            count_next   = cnt_inc;
            left_next    = pending - RUN_W'(1);
            held_next    = code_byte;
          end
        end else if (code_byte[BYTE_W-1 -: 2] == RUN_MARK) begin
          awaiting_next = 1'b1;
          pending_next  = code_byte[RUN_W-1:0];
        end else begin
          emit       = 1'b1;
          emit_done  = cnt_inc == total;
          count_next = cnt_inc;
        end
      end
    end else if (cmd.step) begin
      emit         = 1'b1;
      emit_pixel   = held;
      emit_run_end = run_last;
      emit_done    = run_inc == total;
      count_next   = run_inc;
      left_next    = left - RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      awaiting  <= 1'b0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      count    <= count_next;
      awaiting <= awaiting_next;
      pending  <= pending_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    left <= left_next;
    held <= held_next;
    if (emit) begin
      pixel      <= emit_pixel;
      run_end    <= emit_run_end;
      image_done <= emit_done;
    end
  end

  assign stat.slot_free = !out_valid || out_ready;
  assign stat.total_ok  = total_ok;
  assign stat.run_start = run_start;
  assign stat.run_last  = run_last;

endmodule

// File: hw/rtl/pcx_rle_decoder.sv
// A literal byte's pixel is registered and appears in the cycle after its transfer.
// Throughput: one literal byte per cycle while the output is not stalled; a run of
// n pixels holds the input after its value byte while the output register repeats it.
// A configuration write holds the input while the pixel total
// is recomputed by the side multiplier. Reset is synchronous and restores
// 320 x 240 with an empty run and a cleared pixel count.
module pcx_rle_decoder #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pcx_rle_pkg::CFG_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]  code_byte,
  input  logic                            image_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcx_rle_pkg::BYTE_W-1:0]  pixel,
  output logic                            run_end,
  output logic                            image_done
);
  import pcx_rle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcx_rle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcx_rle_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .code_byte   (code_byte),
    .image_start (image_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel       (pixel),
    .run_end     (run_end),
    .image_done  (image_done),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// File: hw/rtl/pcx_rle_chk.sv
`include "pcx_rle_decoder_defines.svh"

module pcx_rle_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pcx_rle_pkg::BYTE_W-1:0] pixel,
  input logic                           run_end,
  input logic                           image_done
);
  // hold a stalled transfer
  `PCX_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pixel))
  // a clipped run ends with the image
  `PCX_ASSERT_NOW(a_done_ends_run, clk, rst, out_valid && image_done, run_end)
  // no byte taken while a run still repeats
  `PCX_ASSERT_NOW(a_run_blocks_in, clk, rst, out_valid && !run_end, !in_ready)
  // total recompute after a register write
  `PCX_ASSERT_NEXT(a_cfg_blocks_in, clk, rst, cfg_we, !in_ready)

endmodule

bind pcx_rle_decoder pcx_rle_chk u_chk (.*);

// File: test/tb_pcx_rle_decoder.sv
module tb_pcx_rle_decoder;
  import pcx_rle_pkg::*;

  localparam int unsigned MAX_SIDE    = 4096;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYC  = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] px;
    logic              last;
    logic              done;
  } pixel_rec_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [BYTE_W-1:0]  code_byte;
  logic               image_start;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  pixel;
  logic               run_end;
  logic               image_done;

  // decoder shadow state
  logic [CFG_W-1:0]   side_w;
  logic [CFG_W-1:0]   side_h;
  logic               run_pending;
  logic [RUN_W-1:0]   run_len;
  logic [24:0]        pixel_count;

  pixel_rec_t         expected_pixels[$];

  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        errors = 0;
  int unsigned        bytes_sent = 0;
  int unsigned        pixels_seen = 0;
  int unsigned        images_seen = 0;
  int unsigned        cycle_count = 0;

  pcx_rle_decoder #(.MAX_SIDE(MAX_SIDE)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_byte   (code_byte),
    .image_start (image_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel       (pixel),
    .run_end     (run_end),
    .image_done  (image_done)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic int unsigned image_total();
    return clamp_side(side_w) * clamp_side(side_h);
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 30) $display("check: %s at cycle %0d", msg, cycle_count);
    errors++;
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic s);
    int unsigned total;
    int unsigned remain;
    int unsigned n;
    pixel_rec_t  rec;
    total = image_total();
    if (s) begin
      pixel_count = '0;
      run_pending = 1'b0;
      run_len     = '0;
    end
    if (pixel_count >= total) return;
    remain = total - 32'(pixel_count);
    if (run_pending) begin
      run_pending = 1'b0;
      n = 32'(run_len);
      run_len = '0;
      if (n > remain) n = remain;
      for (int i = 0; i < n; i++) begin
        pixel_count++;
        rec.px   = b;
        rec.last = (i + 1 == n);
        rec.done = (pixel_count == total);
        expected_pixels.push_back(rec);
      end
    end else if (b[7:6] == RUN_MARK) begin
      run_pending = 1'b1;
      run_len     = b[RUN_W-1:0];
    end else begin
      pixel_count++;
      rec.px   = b;
      rec.last = 1'b1;
      rec.done = (pixel_count == total);
      expected_pixels.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    pixel_rec_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (image_done) images_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %02h with nothing pending", pixel));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel !== want.px)
            report_mismatch($sformatf("pixel %02h, want %02h", pixel, want.px));
          if (run_end !== want.last)
            report_mismatch($sformatf("run_end %b, want %b", run_end, want.last));
          if (image_done !== want.done)
            report_mismatch($sformatf("image_done %b, want %b", image_done, want.done));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    code_byte   <= b;
    image_start <= s;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, s);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) side_w = val;
    else side_h = val;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic fill_image(input int unsigned max_bytes);
    int unsigned n;
    logic [RUN_W-1:0] cnt;
    n = 0;
    while (n < max_bytes && (n == 0 || pixel_count < image_total())) begin
      if ($urandom_range(9) < 7) begin
        cnt = RUN_W'($urandom_range(63));
        send_byte({RUN_MARK, cnt}, n == 0);
        send_byte(BYTE_W'($urandom_range(255)), 1'b0);
        n += 2;
      end else begin
        send_byte(BYTE_W'($urandom_range(8'hBF)), n == 0);
        n += 1;
      end
    end
  endtask

  task automatic test_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC5, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hC2, 1'b0);
    // restart while a run value is outstanding
    send_byte(8'h2A, 1'b1);
  endtask

  task automatic test_clip_and_done();
    set_size(13'd3, 13'd2);
    send_byte(8'h11, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hC4, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hC2, 1'b1);
    send_byte(8'h44, 1'b0);
    send_byte(8'hC9, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'hC5, 1'b1);
    send_byte(8'h77, 1'b0);
    send_byte(8'h3C, 1'b0);
  endtask

  task automatic test_side_clamp();
    set_size(13'd0, 13'd0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h34, 1'b0);
    set_size(13'h1FFF, 13'd0);
    fill_image(8);
    set_size(13'd0, 13'h1FFF);
    fill_image(8);
    set_size(13'd4096, 13'd4096);
    fill_image(8);
    set_size(13'h1FFF, 13'h1FFF);
    fill_image(8);
  endtask

  task automatic test_resize_mid_image();
    set_size(13'd8, 13'd8);
    send_byte(8'hD4, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC5, 1'b0);
    // shrink below the pixels already out
    set_size(13'd4, 13'd4);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h02, 1'b0);
    set_size(13'd4, 13'd8);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  task automatic test_random_images();
    int unsigned target;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      target = bytes_sent + 8;
      while (bytes_sent < target) begin
        case ($urandom_range(7))
          0: w = '0;
          1: w = CFG_W'($urandom_range(13, 8191));
          default: w = CFG_W'($urandom_range(1, 12));
        endcase
        h = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(8191)) :
                                       CFG_W'($urandom_range(1, 12));
        set_size(w, h);
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 4))
            send_byte(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
          fill_image(target - bytes_sent + 1);
        end
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    code_byte   = '0;
    image_start = 1'b0;
    side_w      = WIDTH_RESET;
    side_h      = HEIGHT_RESET;
    run_pending = 1'b0;
    run_len     = '0;
    pixel_count = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    test_defaults();
    test_clip_and_done();
    test_side_clamp();
    test_resize_mid_image();
    test_random_images();
    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d code bytes, %0d pixels and %0d finished images", bytes_sent,
             pixels_seen, images_seen);
    $display("with literals, runs, clipped and empty runs, clamped sizes and resizes");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pcx_rle_pkg.sv
hw/rtl/pcx_rle_ctrl.sv
hw/rtl/pcx_rle_dp.sv
hw/rtl/pcx_rle_decoder.sv
hw/rtl/pcx_rle_chk.sv
test/tb_pcx_rle_decoder.sv
